@@ hdl/evt_pkg.sv @@
// ----------------------------------------------------------------------------
// EEVDF virtual time tracker package
// Shared types, command codes and constants.
// ----------------------------------------------------------------------------
package evt_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 27;
    localparam logic [26:0] DEFAULT_SLICE_RST = 27'd750000;
    localparam logic [26:0] TICK_LENGTH_RST = 27'd4000000;
    localparam int unsigned DIV_W = 64;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_ADVANCE = 3'd2,
        CMD_SETCUR  = 3'd3,
        CMD_AVERAGE = 3'd4,
        CMD_ELIG    = 3'd5,
        CMD_LAG     = 3'd6,
        CMD_PLACE   = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_SLICE = 2'd0,
        REG_TICK_LENGTH   = 2'd1,
        REG_PLACE_LAG_EN  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]         command;
        logic [63:0]        vruntime;
        logic [16:0]        weight;
        logic               on_rq;
        logic [31:0]        slice;
        logic [62:0]        base_advance;
        logic signed [63:0] saved_lag;
        logic               queue_busy;
    } t_in_word;

    typedef struct packed {
        logic [63:0] value;
        logic        eligible;
    } t_out_word;

    // datapath operation selects
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_C,
        OP_UPDATE,
        OP_AVG_DIV,
        OP_AVG_DONE,
        OP_LIM_DIV,
        OP_LAG_CLAMP,
        OP_PLC_MUL,
        OP_PLC_DIV,
        OP_PLC_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_ctl_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_ctl_sts;

endpackage

@@ hdl/evt_divider.sv @@
// ----------------------------------------------------------------------------
// Unsigned restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module evt_divider
    import evt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_W-1:0]  o_quo
);

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                r_rem <= w_diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo = r_quo;

endmodule

@@ hdl/evt_datapath.sv @@
// ----------------------------------------------------------------------------
// EEVDF tracker datapath
// State registers, 32x32 partial product multiplier and shared divider.
// ----------------------------------------------------------------------------
module evt_datapath
    import evt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_word,
    input  t_ctl_cmd              i_cmd,
    output t_ctl_sts              o_sts,
    output t_out_word             o_result
);

    logic [26:0] r_default_slice;
    logic [26:0] r_tick_length;
    logic        r_place_en;

    logic [63:0] r_wsum;
    logic [31:0] r_load;
    logic [63:0] r_base;
    logic        r_cur_valid;
    logic [63:0] r_cur_vr;
    logic [16:0] r_cur_w;

    t_in_word    r_in;
    logic [63:0] r_key;
    logic [63:0] r_fsum;
    logic [63:0] r_fload;
    logic [63:0] r_mop_a;
    logic [63:0] r_mop_b;
    logic [63:0] r_prod;
    logic [63:0] r_avg;
    logic        r_neg;
    logic        r_step;
    t_out_word   r_out;

    logic        w_div_start;
    logic [63:0] w_div_num;
    logic [63:0] w_div_den;
    logic [63:0] w_quo;
    logic [63:0] w_pp;
    logic [63:0] w_span;
    logic [63:0] w_slice;
    logic [63:0] w_lag;
    logic [63:0] w_nlim;
    logic [63:0] w_q;

    evt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (o_sts.div_busy),
        .o_done  (o_sts.div_done),
        .o_quo   (w_quo)
    );

    assign w_div_start = i_cmd.div_start;

    // wrapping 64-bit product from 32x32 partial products:
    // step 0: lo*lo, step 1: + (lo_a*hi_b + hi_a*lo_b) << 32 done over two ops
    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_A: w_pp = {32'd0, r_mop_a[31:0]} * {32'd0, r_mop_b[31:0]};
            OP_MUL_B: w_pp = {r_mop_a[31:0] * r_mop_b[63:32], 32'd0};
            OP_MUL_C: w_pp = {r_mop_a[63:32] * r_mop_b[31:0], 32'd0};
            default:  w_pp = '0;
        endcase
    end

    always_comb begin
        w_slice = (r_in.slice != 32'd0) ? {32'd0, r_in.slice} : {37'd0, r_default_slice};
        w_span = {w_slice[62:0], 1'b0};
        if (w_span < {37'd0, r_tick_length}) w_span = {37'd0, r_tick_length};
        w_lag = r_avg - r_in.vruntime;
        w_nlim = 64'd0 - w_quo;
        w_q = r_neg ? 64'd0 - w_quo : w_quo;
    end

    always_comb begin
        w_div_num = '0;
        w_div_den = 64'd1;
        unique case (i_cmd.op)
            OP_AVG_DIV: begin
                w_div_num = r_fsum[63] ? (64'd0 - r_fsum) + r_fload - 64'd1 : r_fsum;
                w_div_den = r_fload;
            end
            OP_LIM_DIV: begin
                w_div_num = {w_span[53:0], 10'd0};
                w_div_den = (r_in.weight != 17'd0) ? {47'd0, r_in.weight} : 64'd1;
            end
            OP_PLC_DIV: begin
                w_div_num = r_prod[63] ? 64'd0 - r_prod : r_prod;
                w_div_den = (r_fload != 64'd0) ? r_fload : 64'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_slice <= DEFAULT_SLICE_RST;
            r_tick_length <= TICK_LENGTH_RST;
            r_place_en <= 1'b1;
            r_wsum <= '0;
            r_load <= '0;
            r_base <= '0;
            r_cur_valid <= 1'b0;
            r_cur_vr <= '0;
            r_cur_w <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DEFAULT_SLICE: r_default_slice <= i_cfg_data;
                    REG_TICK_LENGTH:   r_tick_length <= i_cfg_data;
                    REG_PLACE_LAG_EN:  r_place_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_UPDATE) begin
                case (r_in.command)
                    CMD_ADD: begin
                        r_wsum <= r_wsum + r_prod;
                        r_load <= r_load + {15'd0, r_in.weight};
                    end
                    CMD_REMOVE: begin
                        r_wsum <= r_wsum - r_prod;
                        r_load <= r_load - {15'd0, r_in.weight};
                    end
                    CMD_ADVANCE: begin
                        r_wsum <= r_wsum - r_prod;
                        r_base <= r_base + {1'b0, r_in.base_advance};
                    end
                    CMD_SETCUR: begin
                        r_cur_valid <= r_in.on_rq;
                        r_cur_vr <= r_in.on_rq ? r_in.vruntime : 64'd0;
                        r_cur_w <= r_in.on_rq ? r_in.weight : 17'd0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // operation sequence: LATCH, MUL(A,B,C) x2 passes, then per command
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_in <= i_word;
                r_step <= 1'b0;
                r_out <= '0;
                r_fsum <= r_wsum;
                r_fload <= {32'd0, r_load} + (r_cur_valid ? {47'd0, r_cur_w} : 64'd0);
                r_mop_a <= r_cur_vr - r_base;
                r_mop_b <= r_cur_valid ? {47'd0, r_cur_w} : 64'd0;
                r_key <= i_word.vruntime - r_base;
            end
            OP_MUL_A: r_prod <= w_pp;
            OP_MUL_B: r_prod <= r_prod + w_pp;
            OP_MUL_C: begin
                r_step <= 1'b1;
                if (!r_step) begin
                    // first pass: current entity term
                    r_fsum <= r_fsum + r_prod + w_pp;
                    case (r_in.command)
                        CMD_ADD, CMD_REMOVE: begin
                            r_mop_a <= r_key;
                            r_mop_b <= {47'd0, r_in.weight};
                        end
                        CMD_ADVANCE: begin
                            r_mop_a <= {32'd0, r_load};
                            r_mop_b <= {1'b0, r_in.base_advance};
                        end
                        CMD_ELIG: begin
                            r_mop_a <= r_key;
                            r_mop_b <= r_fload;
                        end
                        default: begin
                            r_mop_a <= r_in.saved_lag;
                            r_mop_b <= r_fload + {47'd0, r_in.weight};
                        end
                    endcase
                end else begin
                    r_prod <= r_prod + w_pp;
                end
            end
            OP_UPDATE: begin
                if (r_in.command == CMD_ELIG) begin
                    r_out.eligible <= ($signed(r_fsum) >= $signed(r_prod));
                end
            end
            OP_AVG_DIV: r_neg <= r_fsum[63];
            OP_AVG_DONE: begin
                if (r_fload == 64'd0) r_avg <= r_base + r_fsum;
                else r_avg <= r_base + w_q;
                if (r_fload == 64'd0) r_out.value <= r_base + r_fsum;
                else r_out.value <= r_base + w_q;
            end
            OP_LIM_DIV: ;
            OP_LAG_CLAMP: begin
                if ($signed(w_lag) > $signed(w_quo)) r_out.value <= w_quo;
                else if ($signed(w_nlim) > $signed(w_lag)) r_out.value <= w_nlim;
                else r_out.value <= w_lag;
            end
            OP_PLC_MUL: ;
            OP_PLC_DIV: r_neg <= r_prod[63];
            OP_PLC_DONE: begin
                if (r_place_en && r_in.queue_busy) r_out.value <= r_avg - w_q;
                else r_out.value <= r_avg;
            end
            default: ;
        endcase
    end

    assign o_result = r_out;

endmodule

@@ hdl/evt_ctrl.sv @@
// ----------------------------------------------------------------------------
// EEVDF tracker controller
// Sequences multiply passes, divides and state updates for one word.
// ----------------------------------------------------------------------------
module evt_ctrl
    import evt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cmd     i_command,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_ctl_cmd o_cmd,
    input  t_ctl_sts i_sts
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MA     = 14'b00000000000010,
        S_MB     = 14'b00000000000100,
        S_MC     = 14'b00000000001000,
        S_UPD    = 14'b00000000010000,
        S_AVGS   = 14'b00000000100000,
        S_AVGW   = 14'b00000001000000,
        S_AVGD   = 14'b00000010000000,
        S_LIMS   = 14'b00000100000000,
        S_LIMW   = 14'b00001000000000,
        S_CLAMP  = 14'b00010000000000,
        S_PLCS   = 14'b00100000000000,
        S_PLCW   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_command;
    logic   r_pass;
    logic   r_out_valid;

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        o_cmd.div_start = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.op = OP_LATCH;
                n_state = S_MA;
            end
            S_MA: begin o_cmd.op = OP_MUL_A; n_state = S_MB; end
            S_MB: begin o_cmd.op = OP_MUL_B; n_state = S_MC; end
            S_MC: begin
                o_cmd.op = OP_MUL_C;
                if (!r_pass) n_state = S_MA;
                else if (r_command == CMD_AVERAGE || r_command == CMD_LAG
                         || r_command == CMD_PLACE) n_state = S_AVGS;
                else n_state = S_UPD;
            end
            S_UPD: begin o_cmd.op = OP_UPDATE; n_state = S_OUT; end
            S_AVGS: begin
                o_cmd.op = OP_AVG_DIV; o_cmd.div_start = 1'b1; n_state = S_AVGW;
            end
            S_AVGW: if (i_sts.div_done) n_state = S_AVGD;
            S_AVGD: begin
                o_cmd.op = OP_AVG_DONE;
                if (r_command == CMD_LAG) n_state = S_LIMS;
                else if (r_command == CMD_PLACE) n_state = S_PLCS;
                else n_state = S_OUT;
            end
            S_LIMS: begin
                o_cmd.op = OP_LIM_DIV; o_cmd.div_start = 1'b1; n_state = S_LIMW;
            end
            S_LIMW: if (i_sts.div_done) n_state = S_CLAMP;
            S_CLAMP: begin o_cmd.op = OP_LAG_CLAMP; n_state = S_OUT; end
            S_PLCS: begin
                o_cmd.op = OP_PLC_DIV; o_cmd.div_start = 1'b1; n_state = S_PLCW;
            end
            S_PLCW: if (i_sts.div_done) begin
                o_cmd.op = OP_PLC_DONE; n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass <= 1'b0;
            r_out_valid <= 1'b0;
            r_command <= CMD_ADD;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid && o_ready) begin
                r_command <= i_command;
                r_pass <= 1'b0;
            end
            if (r_state == S_MC) r_pass <= 1'b1;
            if (r_state == S_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
        end
    end

endmodule

@@ hdl/eevdf_virtual_time_tracker.sv @@
// ----------------------------------------------------------------------------
// EEVDF virtual time tracker
// Add/remove/advance/set/eligible words need no divide; average runs one
// restoring divide, and lag and place run two divides in series.
// One word is in flight at a time: the next word is accepted only after the
// result handshake. Reset is synchronous active low; run-queue state clears
// to zero and the config registers take their reset defaults.
// ----------------------------------------------------------------------------
module eevdf_virtual_time_tracker
    import evt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    evt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (t_cmd'(i_data.command)),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    evt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (i_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_data)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepted while result pending");
    a_div_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_busy |-> !w_cmd.div_start) else $error("divider restarted");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_data)) else $error("result changed");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Virtual time tracker testbench
// Drives command words through a bursty sender against a stalling receiver,
// predicts result words from a local copy of the run-queue sums (some directed
// words carry fixed expectations), and compares value and eligibility field by
// field. Registers change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import evt_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int DRAIN_CYCLES = 200;
    localparam int IN_W = $bits(t_in_word);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_word    i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_word   o_data;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    eevdf_virtual_time_tracker u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] key_sum;
    logic [31:0] load_sum;
    logic [63:0] base_vr;
    logic        cur_on;
    logic [63:0] cur_vr;
    logic [16:0] cur_w;
    logic [26:0] slice_dflt;
    logic [26:0] tick_len;
    logic        lag_en;

    t_out_word   result_q[$];
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          cycles = 0;
    int          cmd_count[8];

    function automatic logic [63:0] sum_with_cur(output logic [63:0] ld);
        logic [63:0] s;
        s = key_sum;
        ld = {32'd0, load_sum};
        if (cur_on) begin
            s = s + (cur_vr - base_vr) * {47'd0, cur_w};
            ld = ld + {47'd0, cur_w};
        end
        return s;
    endfunction

    function automatic logic [63:0] floor_avg();
        logic [63:0] ld, s, mag;
        s = sum_with_cur(ld);
        if (ld == 0) return base_vr + s;
        if (s[63]) begin
            mag = -s;
            return base_vr - ((mag + ld - 1) / ld);
        end
        return base_vr + s / ld;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word r;
        logic [63:0] ld, s, span, lim, lag, mag, avg, wd;
        r = '0;
        case (t_cmd'(w.command))
            CMD_ADD: begin
                key_sum = key_sum + (w.vruntime - base_vr) * {47'd0, w.weight};
                load_sum = load_sum + {15'd0, w.weight};
            end
            CMD_REMOVE: begin
                key_sum = key_sum - (w.vruntime - base_vr) * {47'd0, w.weight};
                load_sum = load_sum - {15'd0, w.weight};
            end
            CMD_ADVANCE: begin
                key_sum = key_sum - {32'd0, load_sum} * {1'b0, w.base_advance};
                base_vr = base_vr + {1'b0, w.base_advance};
            end
            CMD_SETCUR: begin
                cur_on = w.on_rq;
                cur_vr = w.on_rq ? w.vruntime : '0;
                cur_w = w.on_rq ? w.weight : '0;
            end
            CMD_AVERAGE: r.value = floor_avg();
            CMD_ELIG: begin
                s = sum_with_cur(ld);
                r.eligible = $signed(s) >= $signed((w.vruntime - base_vr) * ld);
            end
            CMD_LAG: begin
                span = (w.slice != 0) ? {32'd0, w.slice} : {37'd0, slice_dflt};
                span = span * 2;
                if (span < {37'd0, tick_len}) span = {37'd0, tick_len};
                wd = (w.weight != 0) ? {47'd0, w.weight} : 64'd1;
                lim = (span * 1024) / wd;
                lag = floor_avg() - w.vruntime;
                if ($signed(lag) > $signed(lim)) lag = lim;
                else if ($signed(-lim) > $signed(lag)) lag = -lim;
                r.value = lag;
            end
            default: begin
                avg = floor_avg();
                lag = '0;
                if (lag_en && w.queue_busy) begin
                    ld = {32'd0, load_sum};
                    if (cur_on) ld = ld + {47'd0, cur_w};
                    lag = w.saved_lag * (ld + {47'd0, w.weight});
                    mag = lag[63] ? -lag : lag;
                    mag = mag / ((ld != 0) ? ld : 64'd1);
                    lag = lag[63] ? -mag : mag;
                end
                r.value = avg - lag;
            end
        endcase
        return r;
    endfunction

    // sender burst control
    int gap_left = 0;
    int burst_left = 0;

    task automatic send_word(t_in_word w);
        while (gap_left > 0) begin
            gap_left--;
            @(negedge i_clk);
        end
        i_data <= w;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        result_q.push_back(predict_word(w));
        words_in++;
        cmd_count[w.command]++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        if (gap_left > 0) i_valid <= 1'b0;
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [26:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            REG_DEFAULT_SLICE: slice_dflt = val;
            REG_TICK_LENGTH:   tick_len = val;
            default:           lag_en = val[0];
        endcase
    endtask

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 3) != 0);
                2: i_ready <= (cycles % 37) > 25;
                default: i_ready <= $urandom_range(0, 1);
            endcase
            if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            words_out++;
            if (result_q.size() == 0) begin
                $error("unexpected word: value %h eligible %b", o_data.value, o_data.eligible);
                errors++;
            end else begin
                t_out_word e;
                e = result_q.pop_front();
                if (o_data.value !== e.value) begin
                    $error("value: expected %h actual %h", e.value, o_data.value);
                    errors++;
                end
                if (o_data.eligible !== e.eligible) begin
                    $error("eligible: expected %b actual %b", e.eligible, o_data.eligible);
                    errors++;
                end
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic t_in_word make_word(t_cmd c, logic [63:0] vr, logic [16:0] wt,
                                           logic onrq, logic [31:0] sl, logic [62:0] adv,
                                           logic [63:0] lagv, logic busy);
        t_in_word w;
        w.command = c;
        w.vruntime = vr;
        w.weight = wt;
        w.on_rq = onrq;
        w.slice = sl;
        w.base_advance = adv;
        w.saved_lag = lagv;
        w.queue_busy = busy;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random traffic: most vruntimes lie near the running average
    function automatic t_in_word rand_word();
        t_in_word w;
        logic [255:0] raw;
        logic [63:0] near;
        int sel;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom()};
        w = raw[IN_W-1:0];
        sel = $urandom_range(0, 99);
        near = floor_avg() + {{40{1'b0}}, 24'($urandom())} - 64'd8388608;
        if (sel < 85) w.vruntime = near;
        if ($urandom_range(0, 3) != 0) w.weight = 17'($urandom_range(1, 88761));
        if ($urandom_range(0, 3) != 0) w.base_advance = 63'($urandom_range(0, 1000000));
        if ($urandom_range(0, 2) != 0) w.saved_lag = 64'(int'($urandom_range(0, 20000000)) - 10000000);
        if ($urandom_range(0, 2) == 0) w.slice = 0;
        else if ($urandom_range(0, 1) == 0) w.slice = $urandom_range(1, 10000000);
        return w;
    endfunction

    typedef struct {
        t_in_word    w;
        logic        known;
        t_out_word   r;
    } t_row;

    t_row rows[$];

    initial begin
        t_out_word z;
        z = '0;
        key_sum = '0; load_sum = '0; base_vr = '0; cur_on = 0; cur_vr = '0; cur_w = '0;
        slice_dflt = DEFAULT_SLICE_RST; tick_len = TICK_LENGTH_RST; lag_en = 1'b1;

        // after reset: average of empty queue is zero, empty sum is eligible
        rows.push_back('{make_word(CMD_AVERAGE, '1, 17'd1, 0, 0, 0, 0, 0), 1, z});
        rows.push_back('{make_word(CMD_ELIG, 64'd0, 17'd1, 0, 0, 0, 0, 0), 1, 65'd1});
        rows.push_back('{make_word(CMD_PLACE, 64'd5, 17'd1, 0, 0, 0, 64'd100, 1), 1, 65'(64'(-100) << 1)});
        rows.push_back('{make_word(CMD_ADD, 64'd1000, 17'd88761, 0, 0, 0, 0, 0), 1, z});
        rows.push_back('{make_word(CMD_ADD, '1, 17'd1, 0, 0, 0, 0, 0), 1, z});
        rows.push_back('{make_word(CMD_AVERAGE, 0, 17'd1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_LAG, 0, 17'd0, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_LAG, '1, 17'd88761, 0, '1, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_LAG, 64'h8000_0000_0000_0000, 17'd1, 0, 32'd1, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_SETCUR, 64'd7777, 17'd1024, 1, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_ELIG, '1, 17'd1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_ELIG, 64'h7fff_ffff_ffff_ffff, 17'd1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_ADVANCE, 0, 17'd1, 0, 0, '1, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_ADVANCE, 0, 17'd1, 0, 0, 63'd12345, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_AVERAGE, 0, 17'd1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_PLACE, 0, 17'd88761, 0, 0, 0, 64'h8000_0000_0000_0000, 1), 0, z});
        rows.push_back('{make_word(CMD_PLACE, 0, 17'd3, 0, 0, 0, '1, 0), 0, z});
        rows.push_back('{make_word(CMD_PLACE, 0, 17'd3, 0, 0, 0, 64'h7fff_ffff_ffff_ffff, 1), 0, z});
        rows.push_back('{make_word(CMD_SETCUR, '1, '1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_REMOVE, '1, 17'd1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_REMOVE, 64'd1000, 17'd88761, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_ADD, 64'h7000_0000_0000_0000, '1, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_word(CMD_AVERAGE, 0, 17'd1, 0, 0, 0, 0, 0), 0, z});

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            send_word(rows[i].w);
            if (rows[i].known) begin
                void'(result_q.pop_back());
                result_q.push_back(rows[i].r);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            go_idle();
            case (phase)
                0: begin write_reg(REG_DEFAULT_SLICE, 27'd1); write_reg(REG_TICK_LENGTH, 27'd1);
                          write_reg(REG_PLACE_LAG_EN, 27'd0); end
                1: begin write_reg(REG_DEFAULT_SLICE, 27'd100000000);
                          write_reg(REG_TICK_LENGTH, 27'd100000000);
                          write_reg(REG_PLACE_LAG_EN, 27'd1); end
                default: begin
                    write_reg(REG_DEFAULT_SLICE, 27'($urandom_range(1, 100000000)));
                    write_reg(REG_TICK_LENGTH, 27'($urandom_range(1, 100000000)));
                    write_reg(REG_PLACE_LAG_EN, 27'($urandom_range(0, 1)));
                end
            endcase
            i_cfg_we <= 1'b0;
            repeat (100) send_word(rand_word());
        end

        go_idle();
        $display("covered %0d words in, %0d words out over %0d cycles", words_in, words_out,
                 cycles);
        $display("per command: add %0d rem %0d adv %0d cur %0d avg %0d elig %0d lag %0d plc %0d",
                 cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
                 cmd_count[5], cmd_count[6], cmd_count[7]);
        if (errors == 0 && result_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
